@@ design/ham74_pkg.sv @@
// shared types, constants and code functions for the byte-sliced hamming (7,4) codec
package ham74_pkg;

	localparam int unsigned GroupMax = 7;

	typedef logic [7:0] byte_t;
	typedef byte_t [GroupMax-1:0] group_t;
	typedef logic [2:0] count_t;

	typedef enum logic {
		MODE_ENCODE = 1'b0,
		MODE_DECODE = 1'b1
	} mode_t;

	localparam count_t ENC_LAST_IDX = 3'd3;
	localparam count_t DEC_LAST_IDX = 3'd6;
	localparam count_t ENC_COUNT    = 3'd7;
	localparam count_t DEC_COUNT    = 3'd4;

	// gathered bytes with the incoming byte placed, plus whether the group closes
	typedef struct packed {
		group_t bytes;
		logic   closes;
	} gather_t;

	// a finished group ready for the output shifter
	typedef struct packed {
		group_t bytes;
		count_t count;
		logic   last;
	} result_t;

	function automatic group_t ham74_encode(group_t w);
		group_t r;
		r    = w;
		r[4] = w[0] ^ w[1] ^ w[3];
		r[5] = w[0] ^ w[2] ^ w[3];
		r[6] = w[1] ^ w[2] ^ w[3];
		return r;
	endfunction

	function automatic group_t ham74_decode(group_t w);
		group_t r;
		byte_t  s0;
		byte_t  s1;
		byte_t  s2;
		s0   = w[0] ^ w[1] ^ w[3] ^ w[4];
		s1   = w[0] ^ w[2] ^ w[3] ^ w[5];
		s2   = w[1] ^ w[2] ^ w[3] ^ w[6];
		r    = w;
		// per lane: flip the data bit whose check column matches the syndrome
		r[0] = w[0] ^ (s0 & s1 & ~s2);
		r[1] = w[1] ^ (s0 & ~s1 & s2);
		r[2] = w[2] ^ (~s0 & s1 & s2);
		r[3] = w[3] ^ (s0 & s1 & s2);
		return r;
	endfunction

endpackage

@@ design/hamming74_byte_sliced_codec.sv @@
// top level of the byte-sliced hamming (7,4) encoder / decoder
//
//  channel   handshake                 payload
//  input     data_valid / data_stall   data_byte, last
//  result    result_valid / result_stall  out_byte, group_end, stream_end
//  config    cfg_valid / cfg_ready     cfg_data (mode)
//
// a word that closes a group is coded combinationally into the output shifter, which
// sends one word per cycle when not stalled: 7 words per 4 inputs (encode), 4 per 7 (decode)
// words that do not close a group are always taken; a closing word waits unless
// the shifter is empty or its final word leaves on this edge
// reset clears mode to encode and empties the gather and shifter
// a config write discards any partial group
module hamming74_byte_sliced_codec (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_data,
	input  logic             data_valid,
	output logic             data_stall,
	input  ham74_pkg::byte_t data_byte,
	input  logic             last,
	output logic             result_valid,
	input  logic             result_stall,
	output ham74_pkg::byte_t out_byte,
	output logic             group_end,
	output logic             stream_end
);
	import ham74_pkg::*;

	mode_t   mode_q;
	gather_t gather;
	result_t result;
	logic    cfg_write;
	logic    data_accept;
	logic    can_load;
	logic    load;
	logic    last_word;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENCODE;
		end else if (cfg_write) begin
			mode_q <= mode_t'(cfg_data);
		end
	end

	// shifter is free now or frees on this edge
	assign can_load    = !result_valid || (last_word && !result_stall);
	assign data_stall  = gather.closes && !can_load;
	assign data_accept = data_valid && !data_stall;
	assign load        = data_accept && gather.closes;

	ham74_gather u_gather (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.data_byte (data_byte),
		.last      (last),
		.accept    (data_accept),
		.clear     (cfg_write),
		.gather    (gather)
	);

	ham74_code u_code (
		.mode   (mode_q),
		.gather (gather),
		.last   (last),
		.result (result)
	);

	ham74_serial u_serial (
		.clk          (clk),
		.arst_n       (arst_n),
		.result       (result),
		.load         (load),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.last_word    (last_word),
		.out_byte     (out_byte),
		.group_end    (group_end),
		.stream_end   (stream_end)
	);

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> result_valid)
		else $error("closed group did not reach the output");

	a_stream_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && stream_end) |-> group_end)
		else $error("stream end outside group end");

	a_group_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && group_end && !load) |=> !result_valid)
		else $error("output still valid after group end");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!result_valid || (group_end && !result_stall)))
		else $error("group loaded over pending output");

endmodule

@@ design/ham74_gather.sv @@
// group gather register and fill counter
module ham74_gather (
	input  logic             clk,
	input  logic             arst_n,
	input  ham74_pkg::mode_t mode,
	input  ham74_pkg::byte_t data_byte,
	input  logic             last,
	input  logic             accept,
	input  logic             clear,
	output ham74_pkg::gather_t gather
);
	import ham74_pkg::*;

	group_t grp_q;
	count_t fill_q;
	count_t last_idx;

	assign last_idx = (mode == MODE_DECODE) ? DEC_LAST_IDX : ENC_LAST_IDX;

	always_comb begin
		for (int i = 0; i < GroupMax; i++) begin
			gather.bytes[i] = (count_t'(i) == fill_q) ? data_byte : grp_q[i];
		end
		gather.closes = last || (fill_q == last_idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q  <= '0;
			fill_q <= '0;
		end else if (clear || (accept && gather.closes)) begin
			// unused slots must read as zero for padding
			grp_q  <= '0;
			fill_q <= '0;
		end else if (accept) begin
			grp_q  <= gather.bytes;
			fill_q <= fill_q + 3'd1;
		end
	end

endmodule

@@ design/ham74_code.sv @@
// encode or decode of one gathered group
module ham74_code (
	input  ham74_pkg::mode_t   mode,
	input  ham74_pkg::gather_t gather,
	input  logic               last,
	output ham74_pkg::result_t result
);
	import ham74_pkg::*;

	always_comb begin
		unique case (mode)
			MODE_ENCODE: begin
				result.bytes = ham74_encode(gather.bytes);
				result.count = ENC_COUNT;
			end
			MODE_DECODE: begin
				result.bytes = ham74_decode(gather.bytes);
				result.count = DEC_COUNT;
			end
			default: begin
				result.bytes = gather.bytes;
				result.count = ENC_COUNT;
			end
		endcase
		result.last = last;
	end

endmodule

@@ design/ham74_serial.sv @@
// output shifter that sends a finished group one word per cycle while result_stall is low
module ham74_serial (
	input  logic               clk,
	input  logic               arst_n,
	input  ham74_pkg::result_t result,
	input  logic               load,
	input  logic               result_stall,
	output logic               result_valid,
	output logic               last_word,
	output ham74_pkg::byte_t   out_byte,
	output logic               group_end,
	output logic               stream_end
);
	import ham74_pkg::*;

	group_t shift_q;
	count_t rem_q;
	logic   last_q;

	assign result_valid = (rem_q != 3'd0);
	assign last_word    = (rem_q == 3'd1);
	assign out_byte     = shift_q[0];
	assign group_end    = last_word;
	assign stream_end   = last_word && last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			last_q <= 1'b0;
		end else if (load) begin
			rem_q  <= result.count;
			last_q <= result.last;
		end else if (result_valid && !result_stall) begin
			rem_q  <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= result.bytes;
		end else if (result_valid && !result_stall) begin
			shift_q <= {8'h00, shift_q[GroupMax-1:1]};
		end
	end

endmodule
